[rtl/n2a_pkg.sv]
package n2a_pkg;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_HEX = 2'd1,
    MODE_TWO = 2'd2,
    MODE_FIX = 2'd3
  } mode_t;

  localparam int VALUE_W  = 32;
  localparam int DIGITS   = 10;
  localparam int CHAR_W   = 7;
  localparam int FRAC_W   = 20;
  localparam int FRAC_MAX = 4;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_HEX_OFS = 7'h37;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_QUOTE   = 7'h22;
  localparam logic [CHAR_W-1:0] CHAR_POINT   = 7'h2E;

  localparam logic [FRAC_W-1:0] ROUND_ADJ = 20'd17232;

  // threshold that the remainder must exceed for another fraction digit
  function automatic logic [FRAC_W-1:0] frac_limit(input logic [2:0] k);
    logic [FRAC_W-1:0] r;
    case (k)
      3'd0:    r = 20'd100;
      3'd1:    r = 20'd1000;
      3'd2:    r = 20'd10000;
      3'd3:    r = 20'd100000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

  // index of the highest non-zero digit, zero when all digits are zero
  function automatic logic [3:0] top_index(input bcd_t d);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (d[i] != 4'd0) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) r = CHAR_ZERO + {3'b000, d};
    else r = CHAR_HEX_OFS + {3'b000, d};
    return r;
  endfunction

endpackage

[rtl/n2a_dabble.sv]
module n2a_dabble (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [n2a_pkg::VALUE_W-1:0]    bin_in,
  output logic                           done,
  output n2a_pkg::bcd_t                  bcd
);

  localparam int STEPS  = n2a_pkg::VALUE_W;
  localparam int STEP_W = $clog2(STEPS);

  logic [n2a_pkg::VALUE_W-1:0] bin;
  logic [STEP_W-1:0]           cnt;
  logic                        run;
  n2a_pkg::bcd_t               bcd_adj;
  logic [4*n2a_pkg::DIGITS-1:0] adj_flat;
  logic [4*n2a_pkg::DIGITS-1:0] bcd_next;

  // shift-add-3 step over all digits at once
  always_comb begin
    for (int i = 0; i < n2a_pkg::DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    adj_flat = bcd_adj;
    bcd_next = {adj_flat[4*n2a_pkg::DIGITS-2:0], bin[n2a_pkg::VALUE_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == STEP_W'(STEPS - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(STEPS - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (run) begin
      bin <= {bin[n2a_pkg::VALUE_W-2:0], 1'b0};
      bcd <= bcd_next;
    end
  end

endmodule

[rtl/number_to_ascii_formatter.sv]
// decimal, two-digit and 16.16 modes first convert the magnitude in the 32-step
// shift-add-3 binary to bcd unit before the first character
// hex mode skips the conversion; after the first character, one character per cycle while the output is ready
// the input side stays not ready until the last character is loaded for output
// reset: synchronous, active high; clears the sequencer and the output valid
module number_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode [1:0], value [33:2], zero pad [39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // char_code [6:0], zero pad [7]
  output logic        m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_DIGITS,
    ST_POINT,
    ST_FRAC
  } state_t;

  localparam logic [n2a_pkg::VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [n2a_pkg::VALUE_W-1:0] MOST_POS = 32'h7FFF_FFFF;

  state_t                          state;
  n2a_pkg::mode_t                  mode_reg;
  logic                            neg_reg;
  logic [n2a_pkg::VALUE_W-1:0]     value_reg;
  logic [3:0]                      idx;
  logic [2:0]                      k;
  logic [n2a_pkg::FRAC_W-1:0]      s;
  logic [n2a_pkg::CHAR_W-1:0]      out_char;
  logic                            out_valid;
  logic                            out_last;

  n2a_pkg::mode_t                  in_mode;
  logic [n2a_pkg::VALUE_W-1:0]     in_value;
  logic [n2a_pkg::VALUE_W-1:0]     in_mag;
  logic [n2a_pkg::VALUE_W-1:0]     in_mag_sat;
  logic [n2a_pkg::VALUE_W-1:0]     conv_in;
  logic                            accept;
  logic                            conv_start;
  logic                            conv_done;
  n2a_pkg::bcd_t                   bcd;
  n2a_pkg::bcd_t                   cur_dig;
  logic                            out_free;
  logic                            emit;
  logic                            emit_last;

  logic [n2a_pkg::FRAC_W-1:0]      s_adj;
  logic [n2a_pkg::FRAC_W-1:0]      s_new;
  logic [n2a_pkg::FRAC_W-1:0]      s_first;
  logic                            frac_end;

  assign in_mode    = n2a_pkg::mode_t'(s_tdata[1:0]);
  assign in_value   = s_tdata[33:2];
  assign in_mag     = in_value[n2a_pkg::VALUE_W-1] ? (32'd0 - in_value) : in_value;
  assign in_mag_sat = (in_value == MOST_NEG) ? MOST_POS : in_mag;
  assign conv_in    = (in_mode == n2a_pkg::MODE_FIX) ? {16'd0, in_mag_sat[31:16]} : in_mag;

  assign s_tready   = !rst && (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign conv_start = accept && (in_mode != n2a_pkg::MODE_HEX);

  n2a_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .bin_in (conv_in),
    .done   (conv_done),
    .bcd    (bcd)
  );

  always_comb begin
    cur_dig = bcd;
    if (mode_reg == n2a_pkg::MODE_HEX) cur_dig = {8'h00, value_reg};
  end

  // fraction digit step, rounding fix on the fifth digit
  always_comb begin
    s_adj = s;
    if (k == 3'(n2a_pkg::FRAC_MAX)) begin
      s_adj = (s > n2a_pkg::ROUND_ADJ) ? s - n2a_pkg::ROUND_ADJ : '0;
    end
    s_new    = ({4'd0, s_adj[15:0]} << 3) + ({4'd0, s_adj[15:0]} << 1);
    s_first  = ({4'd0, s[15:0]} << 3) + ({4'd0, s[15:0]} << 1) + 20'd5;
    frac_end = !(s_new > n2a_pkg::frac_limit(k));
  end

  assign out_free  = !out_valid || m_tready;
  assign emit      = out_free && (state == ST_SIGN || state == ST_DIGITS ||
                                  state == ST_POINT || state == ST_FRAC);
  assign emit_last = (state == ST_DIGITS && idx == 4'd0 && mode_reg != n2a_pkg::MODE_FIX) ||
                     (state == ST_FRAC && frac_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_last  <= emit_last;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_reg  <= in_mode;
            neg_reg   <= in_value[n2a_pkg::VALUE_W-1];
            value_reg <= in_value;
            s         <= {4'd0, in_mag_sat[15:0]};
            state     <= (in_mode == n2a_pkg::MODE_HEX) ? ST_LEAD : ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_done) state <= ST_LEAD;
        end
        ST_LEAD: begin
          idx <= (mode_reg == n2a_pkg::MODE_TWO) ? 4'd1 : n2a_pkg::top_index(cur_dig);
          if (mode_reg == n2a_pkg::MODE_HEX ||
              (neg_reg && (mode_reg == n2a_pkg::MODE_DEC || mode_reg == n2a_pkg::MODE_FIX))) begin
            state <= ST_SIGN;
          end else begin
            state <= ST_DIGITS;
          end
        end
        ST_SIGN: begin
          if (emit) begin
            out_char <= (mode_reg == n2a_pkg::MODE_HEX) ? n2a_pkg::CHAR_QUOTE
                                                        : n2a_pkg::CHAR_MINUS;
            state    <= ST_DIGITS;
          end
        end
        ST_DIGITS: begin
          if (emit) begin
            out_char <= n2a_pkg::digit_char(cur_dig[idx]);
            if (idx == 4'd0) begin
              state <= (mode_reg == n2a_pkg::MODE_FIX) ? ST_POINT : ST_IDLE;
            end else begin
              idx <= idx - 4'd1;
            end
          end
        end
        ST_POINT: begin
          if (emit) begin
            out_char <= n2a_pkg::CHAR_POINT;
            s        <= s_first;
            k        <= '0;
            state    <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (emit) begin
            out_char <= n2a_pkg::CHAR_ZERO + {3'b000, s_adj[19:16]};
            s        <= s_new;
            k        <= k + 3'd1;
            if (frac_end) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input ready right after a transaction");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == ST_CONV)
    else $error("conversion finished outside the conversion state");

  a_last_ends_number: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == ST_IDLE && m_tvalid && m_tlast))
    else $error("last character did not end the number");

  a_two_digit_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGITS && mode_reg == n2a_pkg::MODE_TWO) |-> idx <= 4'd1)
    else $error("two-digit mode beyond its digits");

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FRAC |-> k <= 3'(n2a_pkg::FRAC_MAX))
    else $error("too many fraction digits");

endmodule
